### rtl/vertical_gcli_prediction_cost_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the vertical GCLI prediction cost unit
// Concurrent assertion wrappers; they compile to nothing when NO_ASSERTIONS
// is defined.
// ----------------------------------------------------------------------------
`ifndef VERTICAL_GCLI_PREDICTION_COST_UNIT_MACROS_SVH
`define VERTICAL_GCLI_PREDICTION_COST_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define VGPC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

`define VGPC_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`else

`define VGPC_ASSERT_IMP(lbl, clk, rst, ante, cons)

`define VGPC_ASSERT_NXT(lbl, clk, rst, ante, cons)

`endif

`endif

### rtl/vgpc_pkg.sv
// ----------------------------------------------------------------------------
// Vertical GCLI prediction cost package
// Widths, register indexes and limits shared by the cost unit.
// ----------------------------------------------------------------------------
package vgpc_pkg;

   localparam int GRP_WORDS_DEF = 8;

   localparam int GCLI_W     = 4;
   localparam int CODE_W     = 5;
   localparam int MAX_CODE   = 30;
   localparam int SUM_W      = 17;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 4;

   localparam int REQ_TDATA_W = 8;
   localparam int RSP_TDATA_W = 40;
   localparam int RSP_TUSER_W = 2;

   localparam logic [SUM_W-1:0] SUM_LIMIT = {SUM_W{1'b1}};

   localparam logic [CSR_ADDR_W-1:0] CSR_RUN_MODE          = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_TRUNC_LEVEL       = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_TRUNC_LEVEL_ABOVE = 2'd2;

endpackage

### rtl/vertical_gcli_prediction_cost_unit.sv
// ----------------------------------------------------------------------------
// Vertical GCLI prediction cost unit
// Code length of each word's vertical GCLI residual, with group
// significance flags and running plain and reduction totals per line.
// ----------------------------------------------------------------------------
// The unit takes one word per clock and returns one word per word taken;
// each word is held first in the input register and then in the result
// register, with the clamp, code-length and accumulator logic between the
// two. Back-pressure on the result side stalls both stages, so
// the sustained rate is one word per cycle whenever the result side is ready.
// Group and line state returns to zero after a word carrying tlast; the
// configuration registers keep their values and should be written only
// while no word is in flight.
module vertical_gcli_prediction_cost_unit #(
   parameter int GRP_WORDS = vgpc_pkg::GRP_WORDS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // configuration
   input  logic                                  csr_wen,
   input  logic [vgpc_pkg::CSR_ADDR_W-1:0]       csr_addr,
   input  logic [vgpc_pkg::CSR_DATA_W-1:0]       csr_wdata,
   // input stream
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // [3:0] gcli_value, [7:4] gcli_above
   input  logic [vgpc_pkg::REQ_TDATA_W-1:0]      req_tdata,
   input  logic                                  req_tlast,
   // result stream
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // [4:0] code_bits, [21:5] total_plain, [38:22] total_reduction, [39] zero
   output logic [vgpc_pkg::RSP_TDATA_W-1:0]      rsp_tdata,
   // [0] group_end, [1] group_skip
   output logic [vgpc_pkg::RSP_TUSER_W-1:0]      rsp_tuser,
   output logic                                  rsp_tlast
);

   localparam int GW     = vgpc_pkg::GCLI_W;
   localparam int CW     = vgpc_pkg::CODE_W;
   localparam int SW     = vgpc_pkg::SUM_W;
   localparam int ACC_W  = SW + 1;
   localparam int FILL_W = $clog2(GRP_WORDS + 1);
   localparam int LEN_W  = $clog2(GRP_WORDS * vgpc_pkg::MAX_CODE + 1);

   // configuration registers
   logic          run_mode_ff;
   logic [GW-1:0] tl_ff;
   logic [GW-1:0] tla_ff;

   // input register
   logic          in_valid_ff;
   logic [GW-1:0] in_gcli_ff;
   logic [GW-1:0] in_above_ff;
   logic          in_last_ff;

   // result register
   logic          rsp_valid_ff;
   logic [CW-1:0] rsp_code_ff;
   logic          rsp_end_ff;
   logic          rsp_skip_ff;
   logic [SW-1:0] rsp_plain_ff;
   logic [SW-1:0] rsp_red_ff;
   logic          rsp_last_ff;

   // line state
   logic [LEN_W-1:0]  group_len_ff, group_len_in;
   logic              group_any_ff, group_any_in;
   logic [FILL_W-1:0] group_fill_ff, group_fill_in;
   logic [SW-1:0]     sum_plain_ff, sum_plain_in;
   logic [SW-1:0]     sum_red_ff, sum_red_in;

   logic              advance;
   logic              fire;
   logic [GW-1:0]     g_clamp;
   logic [GW-1:0]     m_clamp;
   logic              d_neg;
   logic [GW-1:0]     d_mag;
   logic [GW-1:0]     lim;
   logic [CW-1:0]     code;
   logic              sig;
   logic [FILL_W-1:0] fill_nxt;
   logic [LEN_W-1:0]  len_nxt;
   logic              any_nxt;
   logic [ACC_W-1:0]  plain_sum;
   logic [SW-1:0]     plain_sat;
   logic [ACC_W-1:0]  red_sum;
   logic [SW-1:0]     red_sat;
   logic              grp_end;
   logic              grp_skip;
   logic              state_zero;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign fire       = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      g_clamp = (in_gcli_ff > tl_ff) ? in_gcli_ff : tl_ff;
      m_clamp = (in_above_ff > tla_ff) ? in_above_ff : tla_ff;
      d_neg   = g_clamp < m_clamp;
      d_mag   = d_neg ? (m_clamp - g_clamp) : (g_clamp - m_clamp);
      lim     = (m_clamp > tl_ff) ? (m_clamp - tl_ff) : '0;
      if (!d_neg && (d_mag > lim)) begin
         code = {1'b0, d_mag} + {1'b0, lim};
      end else if (!d_neg) begin
         code = {d_mag, 1'b0};
      end else begin
         code = {d_mag, 1'b0} - CW'(1);
      end
      sig = run_mode_ff ? (in_gcli_ff > tl_ff) : (d_mag != '0);

      fill_nxt  = group_fill_ff + FILL_W'(1);
      len_nxt   = group_len_ff + LEN_W'(code);
      any_nxt   = group_any_ff | sig;
      plain_sum = {1'b0, sum_plain_ff} + ACC_W'(code);
      plain_sat = plain_sum[SW] ? vgpc_pkg::SUM_LIMIT : plain_sum[SW-1:0];

      grp_end  = in_last_ff || (fill_nxt >= FILL_W'(GRP_WORDS));
      grp_skip = grp_end && !any_nxt;
      red_sum  = {1'b0, sum_red_ff} + ACC_W'(len_nxt) + ACC_W'(fill_nxt);
      red_sat  = grp_skip ? (red_sum[SW] ? vgpc_pkg::SUM_LIMIT : red_sum[SW-1:0])
                          : sum_red_ff;

      group_len_in  = group_len_ff;
      group_any_in  = group_any_ff;
      group_fill_in = group_fill_ff;
      sum_plain_in  = sum_plain_ff;
      sum_red_in    = sum_red_ff;
      if (fire) begin
         if (in_last_ff) begin
            group_len_in  = '0;
            group_any_in  = 1'b0;
            group_fill_in = '0;
            sum_plain_in  = '0;
            sum_red_in    = '0;
         end else if (grp_end) begin
            group_len_in  = '0;
            group_any_in  = 1'b0;
            group_fill_in = '0;
            sum_plain_in  = plain_sat;
            sum_red_in    = red_sat;
         end else begin
            group_len_in  = len_nxt;
            group_any_in  = any_nxt;
            group_fill_in = fill_nxt;
            sum_plain_in  = plain_sat;
            sum_red_in    = red_sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_mode_ff   <= 1'b0;
         tl_ff         <= '0;
         tla_ff        <= '0;
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         group_len_ff  <= '0;
         group_any_ff  <= 1'b0;
         group_fill_ff <= '0;
         sum_plain_ff  <= '0;
         sum_red_ff    <= '0;
      end else begin
         if (csr_wen) begin
            case (csr_addr)
               vgpc_pkg::CSR_RUN_MODE:          run_mode_ff <= csr_wdata[0];
               vgpc_pkg::CSR_TRUNC_LEVEL:       tl_ff       <= csr_wdata[GW-1:0];
               vgpc_pkg::CSR_TRUNC_LEVEL_ABOVE: tla_ff      <= csr_wdata[GW-1:0];
               default: begin
               end
            endcase
         end
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (advance) begin
            rsp_valid_ff <= in_valid_ff;
         end
         group_len_ff  <= group_len_in;
         group_any_ff  <= group_any_in;
         group_fill_ff <= group_fill_in;
         sum_plain_ff  <= sum_plain_in;
         sum_red_ff    <= sum_red_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_gcli_ff  <= req_tdata[GW-1:0];
         in_above_ff <= req_tdata[2*GW-1:GW];
         in_last_ff  <= req_tlast;
      end
      if (fire) begin
         rsp_code_ff  <= code;
         rsp_end_ff   <= grp_end;
         rsp_skip_ff  <= grp_skip;
         rsp_plain_ff <= plain_sat;
         rsp_red_ff   <= red_sat;
         rsp_last_ff  <= in_last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_red_ff, rsp_plain_ff, rsp_code_ff};
   assign rsp_tuser  = {rsp_skip_ff, rsp_end_ff};
   assign rsp_tlast  = rsp_last_ff;

   assign state_zero = (sum_plain_ff == '0) && (sum_red_ff == '0) && (group_fill_ff == '0);

`include "vertical_gcli_prediction_cost_unit_macros.svh"

   `VGPC_ASSERT_IMP(a_fill_below_group, clock, reset, 1'b1, group_fill_ff < FILL_W'(GRP_WORDS))
   `VGPC_ASSERT_IMP(a_line_end_closes_group, clock, reset, rsp_valid_ff && rsp_last_ff, rsp_end_ff)
   `VGPC_ASSERT_IMP(a_skip_only_at_end, clock, reset, rsp_valid_ff && rsp_skip_ff, rsp_end_ff)
   `VGPC_ASSERT_NXT(a_state_clear_after_line, clock, reset, fire && in_last_ff, state_zero)

endmodule
